// ===== src/xmcr_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types of the XMODEM checksum receiver.
// Depends on nothing; every other file of the block imports it.
package xmcr_pkg;

   localparam int unsigned BLOCK_BYTES = 128;

   localparam logic [1:0] KIND_BYTE    = 2'd0;
   localparam logic [1:0] KIND_TIMEOUT = 2'd1;
   localparam logic [1:0] KIND_START   = 2'd2;

   localparam logic [7:0] CH_SOH = 8'h01;
   localparam logic [7:0] CH_EOT = 8'h04;
   localparam logic [7:0] CH_ACK = 8'h06;
   localparam logic [7:0] CH_NAK = 8'h15;
   localparam logic [7:0] CH_CAN = 8'h18;

   localparam logic [3:0] ST_NONE     = 4'd0;
   localparam logic [3:0] ST_HEADER   = 4'd1;
   localparam logic [3:0] ST_NUMBER   = 4'd2;
   localparam logic [3:0] ST_DATA     = 4'd3;
   localparam logic [3:0] ST_ACCEPTED = 4'd4;
   localparam logic [3:0] ST_SUM_BAD  = 4'd5;
   localparam logic [3:0] ST_EOT      = 4'd6;
   localparam logic [3:0] ST_CANCEL   = 4'd7;
   localparam logic [3:0] ST_TIMEOUT  = 4'd8;
   localparam logic [3:0] ST_COMPL    = 4'd9;
   localparam logic [3:0] ST_SEQ      = 4'd10;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_IGNORE_SEQ = 3'd0;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] rx_byte;
   } req_word_type;

   typedef struct packed {
      logic       reply_valid;
      logic [7:0] reply_byte;
      logic       data_valid;
      logic [7:0] data_byte;
      logic [7:0] block_number;
      logic [3:0] status;
      logic       finished;
   } rsp_word_type;

endpackage

// ===== src/xmcr_csr.sv =====
`timescale 1ns / 1ps
// APB-style configuration register of the XMODEM receiver (ignore_sequence).
// Depends on xmcr_pkg.
module xmcr_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [xmcr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready,
   output logic                           ignore_seq
);
   import xmcr_pkg::*;

   logic ignore_seq_ff;
   logic ignore_seq_in;
   logic wr_hit;

   assign csr_pready = 1'b1;
   assign wr_hit = csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr[CSR_ADDR_W-1] == CSR_IGNORE_SEQ[CSR_ADDR_W-1]);
   assign ignore_seq_in = wr_hit ? csr_pwdata[0] : ignore_seq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ignore_seq_ff <= 1'b0;
      end else begin
         ignore_seq_ff <= ignore_seq_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[CSR_ADDR_W-1] == CSR_IGNORE_SEQ[CSR_ADDR_W-1]) begin
         csr_prdata = {31'd0, ignore_seq_ff};
      end
   end

   assign ignore_seq = ignore_seq_ff;

endmodule

// ===== src/xmcr_fsm.sv =====
`timescale 1ns / 1ps
// Session state and per-word block parser of the XMODEM receiver.
// Depends on xmcr_pkg; computes one result word from the registered input word.
module xmcr_fsm (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  xmcr_pkg::req_word_type req_word,
   input  logic                   ignore_seq,
   output xmcr_pkg::rsp_word_type rsp_word
);
   import xmcr_pkg::*;

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_NUM  = 3'd1;
   localparam logic [2:0] PH_INV  = 3'd2;
   localparam logic [2:0] PH_DATA = 3'd3;
   localparam logic [2:0] PH_SUM  = 3'd4;

   localparam logic [1:0] SESS_ACTIVE = 2'd0;
   localparam logic [1:0] SESS_ENDED  = 2'd1;
   localparam logic [1:0] SESS_FAILED = 2'd2;

   logic [2:0] phase_ff, phase_in;
   logic [7:0] cur_block_ff, cur_block_in;
   logic [7:0] last_good_ff, last_good_in;
   logic [7:0] byte_pos_ff, byte_pos_in;
   logic [7:0] sum_ff, sum_in;
   logic [1:0] session_ff, session_in;
   logic       base_valid_ff, base_valid_in;
   logic [7:0] b;

   assign b = req_word.rx_byte;

   always_comb begin
      phase_in      = phase_ff;
      cur_block_in  = cur_block_ff;
      last_good_in  = last_good_ff;
      byte_pos_in   = byte_pos_ff;
      sum_in        = sum_ff;
      session_in    = session_ff;
      base_valid_in = base_valid_ff;
      rsp_word      = '0;
      rsp_word.status = ST_NONE;

      if (req_word.kind == KIND_START) begin
         phase_in      = PH_IDLE;
         cur_block_in  = '0;
         last_good_in  = '0;
         byte_pos_in   = '0;
         sum_in        = '0;
         session_in    = SESS_ACTIVE;
         base_valid_in = 1'b0;
         rsp_word.reply_valid = 1'b1;
         rsp_word.reply_byte  = CH_NAK;
      end else if (req_word.kind == KIND_TIMEOUT) begin
         if (session_ff == SESS_ACTIVE) begin
            rsp_word.status = ST_TIMEOUT;
         end
      end else if (req_word.kind == KIND_BYTE && session_ff == SESS_ACTIVE) begin
         unique case (phase_ff)
            PH_NUM: begin
               cur_block_in = b;
               if (!base_valid_ff) begin
                  last_good_in  = b - 8'd1;
                  base_valid_in = 1'b1;
               end
               phase_in = PH_INV;
               rsp_word.status = ST_NUMBER;
            end
            PH_INV: begin
               if ((8'd255 - cur_block_ff) != b) begin
                  session_in = SESS_FAILED;
                  rsp_word.status = ST_COMPL;
               end else begin
                  phase_in = PH_DATA;
                  rsp_word.status = ST_NUMBER;
               end
            end
            PH_DATA: begin
               rsp_word.data_valid = 1'b1;
               rsp_word.data_byte  = b;
               sum_in = sum_ff + b;
               if (byte_pos_ff != 8'd255) begin
                  byte_pos_in = byte_pos_ff + 8'd1;
               end
               if (byte_pos_in >= 8'(BLOCK_BYTES)) begin
                  phase_in = PH_SUM;
               end
               rsp_word.status = ST_DATA;
            end
            PH_SUM: begin
               if (b == sum_ff) begin
                  if (!ignore_seq && (last_good_ff + 8'd1) != cur_block_ff) begin
                     session_in = SESS_FAILED;
                     rsp_word.status = ST_SEQ;
                  end else begin
                     last_good_in = cur_block_ff;
                     rsp_word.reply_valid = 1'b1;
                     rsp_word.reply_byte  = CH_ACK;
                     rsp_word.status = ST_ACCEPTED;
                  end
               end else begin
                  rsp_word.reply_valid = 1'b1;
                  rsp_word.reply_byte  = CH_NAK;
                  rsp_word.status = ST_SUM_BAD;
               end
               phase_in    = PH_IDLE;
               byte_pos_in = '0;
               sum_in      = '0;
            end
            default: begin
               phase_in = PH_IDLE;
               if (b == CH_SOH) begin
                  byte_pos_in = '0;
                  sum_in      = '0;
                  phase_in    = PH_NUM;
                  rsp_word.status = ST_HEADER;
               end else if (b == CH_EOT || b == CH_CAN) begin
                  rsp_word.reply_valid = 1'b1;
                  rsp_word.reply_byte  = CH_ACK;
                  session_in = SESS_ENDED;
                  rsp_word.status = (b == CH_EOT) ? ST_EOT : ST_CANCEL;
               end
            end
         endcase
      end

      rsp_word.block_number = cur_block_in;
      rsp_word.finished     = (session_in != SESS_ACTIVE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         cur_block_ff  <= '0;
         last_good_ff  <= '0;
         byte_pos_ff   <= '0;
         sum_ff        <= '0;
         session_ff    <= SESS_ACTIVE;
         base_valid_ff <= 1'b0;
      end else if (fire) begin
         phase_ff      <= phase_in;
         cur_block_ff  <= cur_block_in;
         last_good_ff  <= last_good_in;
         byte_pos_ff   <= byte_pos_in;
         sum_ff        <= sum_in;
         session_ff    <= session_in;
         base_valid_ff <= base_valid_in;
      end
   end

   a_over_sticky: assert property (@(posedge clock) disable iff (reset)
      (fire && session_ff != SESS_ACTIVE && req_word.kind != KIND_START)
      |=> (session_ff != SESS_ACTIVE))
      else $error("session left the over state without a start");

   a_data_in_phase: assert property (@(posedge clock) disable iff (reset)
      (fire && rsp_word.data_valid) |-> (phase_ff == PH_DATA))
      else $error("payload byte outside the data phase");

   a_accept_acks: assert property (@(posedge clock) disable iff (reset)
      (fire && rsp_word.status == ST_ACCEPTED)
      |=> (last_good_ff == $past(cur_block_ff) && phase_ff == PH_IDLE))
      else $error("accepted block did not update the sequence");

   a_data_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (byte_pos_ff < 8'(BLOCK_BYTES)))
      else $error("data phase overran the block length");

endmodule

// ===== src/xmodem_checksum_receiver.sv =====
`timescale 1ns / 1ps
// XMODEM checksum receiver: input word register, parser, result word register.
// An accepted word is held in the input word register; its result then goes to the result word register.
// Throughput: one word per cycle while rsp_stall does not hold a full result word register.
// Reset (synchronous, active high) clears the session state, both valid flags
// and ignore_sequence. Depends on xmcr_pkg, xmcr_csr, xmcr_fsm.
module xmodem_checksum_receiver (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_kind,
   input  logic [7:0]                     req_rx_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_reply_valid,
   output logic [7:0]                     rsp_reply_byte,
   output logic                           rsp_data_valid,
   output logic [7:0]                     rsp_data_byte,
   output logic [7:0]                     rsp_block_number,
   output logic [3:0]                     rsp_status,
   output logic                           rsp_finished,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [xmcr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);
   import xmcr_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff, in_word_in;
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff, out_word_in;
   rsp_word_type step_word;
   logic         ignore_seq;
   logic         advance;
   logic         req_take;

   xmcr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .ignore_seq  (ignore_seq)
   );

   xmcr_fsm u_fsm (
      .clock      (clock),
      .reset      (reset),
      .fire       (advance),
      .req_word   (in_word_ff),
      .ignore_seq (ignore_seq),
      .rsp_word   (step_word)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_word_in  = in_word_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_word_in  = '{kind: req_kind, rx_byte: req_rx_byte};
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_word_in  = step_word;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_word_ff  <= in_word_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_reply_valid  = out_word_ff.reply_valid;
   assign rsp_reply_byte   = out_word_ff.reply_byte;
   assign rsp_data_valid   = out_word_ff.data_valid;
   assign rsp_data_byte    = out_word_ff.data_byte;
   assign rsp_block_number = out_word_ff.block_number;
   assign rsp_status       = out_word_ff.status;
   assign rsp_finished     = out_word_ff.finished;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |=> (out_valid_ff && $stable(out_word_ff)))
      else $error("stalled result word was overwritten");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_word_ff)))
      else $error("pending input word was lost");

   a_stall_consistent: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("input stalled without a full result register");

endmodule
